// ===== hw/rtl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

   // Fixed widths of the item fields
   localparam int REQ_W  = 15;
   localparam int OFF_W  = 14;
   localparam int STAT_W = 2;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_NO_FIT  = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   // Request modes
   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [REQ_W-1:0]     req_bytes;
      logic [REQ_W-1:0]     data_offset;
   } req_item_type;

   typedef struct packed {
      status_type           status;
      logic [OFF_W-1:0]     result_offset;
   } rsp_item_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_WNB,
      ST_A_RDN,
      ST_A_WN,
      ST_A_WB,
      ST_F_RD,
      ST_F_CHK,
      ST_F_RDP,
      ST_F_CHKP,
      ST_F_RDN,
      ST_F_CHKN,
      ST_F_RDX,
      ST_F_CHKX,
      ST_F_WB,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator: header memory and the sequencer that walks it.
//
// Keeps a heap of HEAP_BYTES bytes as address-ordered blocks, each described by a header
// entry in an on-chip memory with one entry per 4-byte word. After reset the block clears
// that memory (req_stall stays high), then holds one free block spanning the heap. One item
// is worked at a time. An allocate reads one header per block it passes, then writes the
// split-off remainder, relinks the block after it and writes its own header. A free checks
// its header, merges with free neighbours and relinks the next block. The header memory has
// one read port and one write port. The result sits in an output register, so the next item
// can be taken while it waits.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = 16384,
   parameter int HEADER_BYTES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffha_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffha_pkg::rsp_item_type rsp_item
);

   localparam int WORDS = HEAP_BYTES / 4;
   localparam int IW    = $clog2(WORDS);
   localparam int SZW   = $clog2(HEAP_BYTES + 1);
   localparam int BW    = $clog2(HEAP_BYTES);
   localparam int NW    = ((SZW > 16) ? SZW : 16) + 1;
   localparam int GW    = $clog2(WORDS + 1);

   typedef struct packed {
      logic           marked;
      logic           used;
      logic           has_prev;
      logic [SZW-1:0] size;
      logic [BW-1:0]  prev;
   } entry_type;

   // Byte address lies in the heap and on a word boundary
   function automatic logic addr_ok(input logic [NW-1:0] a);
      return (a < NW'(HEAP_BYTES)) && (a[1:0] == 2'b00);
   endfunction

   function automatic logic [IW-1:0] word_idx(input logic [NW-1:0] a);
      return a[IW+1:2];
   endfunction

   // Header memory
   entry_type mem [WORDS];
   entry_type rdata_ff;
   logic [IW-1:0] rd_idx_c;
   logic          we_c;
   logic [IW-1:0] wr_idx_c;
   entry_type     wr_data_c;

   always_ff @(posedge clock) begin
      if (we_c) begin
         mem[wr_idx_c] <= wr_data_c;
      end
      rdata_ff <= mem[rd_idx_c];
   end

   // Control and working registers
   ffha_pkg::state_type    state_ff, state_in;
   logic [NW-1:0]          addr_ff, addr_in;
   logic [NW-1:0]          aux_ff, aux_in;
   logic [NW-1:0]          need_ff, need_in;
   logic [GW-1:0]          guard_ff, guard_in;
   entry_type              cur_ff, cur_in;
   logic                   split_ff, split_in;
   logic                   merged_ff, merged_in;
   logic                   bad_ff, bad_in;
   logic [IW-1:0]          clr_ff, clr_in;
   ffha_pkg::status_type   stat_ff, stat_in;
   logic [ffha_pkg::OFF_W-1:0] off_ff, off_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ffha_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      aux_ff      <= aux_in;
      need_ff     <= need_in;
      guard_ff    <= guard_in;
      cur_ff      <= cur_in;
      split_ff    <= split_in;
      merged_ff   <= merged_in;
      bad_ff      <= bad_in;
      stat_ff     <= stat_in;
      off_ff      <= off_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign req_stall = (state_ff != ffha_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Next state, memory accesses and register updates
   always_comb begin
      logic [NW-1:0] rem;
      logic [NW-1:0] nx;
      logic [NW-1:0] sum;
      entry_type     e;

      state_in     = state_ff;
      addr_in      = addr_ff;
      aux_in       = aux_ff;
      need_in      = need_ff;
      guard_in     = guard_ff;
      cur_in       = cur_ff;
      split_in     = split_ff;
      merged_in    = merged_ff;
      bad_in       = bad_ff;
      clr_in       = clr_ff;
      stat_in      = stat_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      rd_idx_c     = word_idx(addr_ff);
      we_c         = 1'b0;
      wr_idx_c     = word_idx(addr_ff);
      wr_data_c    = cur_ff;
      rem          = NW'(cur_ff.size) - need_ff;
      nx           = addr_ff + NW'(cur_ff.size);
      sum          = '0;
      e            = rdata_ff;

      // Output register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // Sweep the memory after reset
         ffha_pkg::ST_CLEAR: begin
            we_c      = 1'b1;
            wr_idx_c  = clr_ff;
            wr_data_c = '0;
            if (clr_ff == '0) begin
               wr_data_c.marked = 1'b1;
               wr_data_c.size   = SZW'(HEAP_BYTES);
            end
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(WORDS - 1)) begin
               state_in = ffha_pkg::ST_IDLE;
            end
         end

         ffha_pkg::ST_IDLE: begin
            if (req_valid) begin
               split_in  = 1'b0;
               merged_in = 1'b0;
               off_in    = '0;
               if (req_item.mode == ffha_pkg::MODE_ALLOC) begin
                  need_in  = (NW'(req_item.req_bytes) + NW'(HEADER_BYTES) + NW'(3))
                             & ~NW'(3);
                  addr_in  = '0;
                  guard_in = '0;
                  state_in = ffha_pkg::ST_A_RD;
               end else begin
                  addr_in  = NW'(req_item.data_offset) - NW'(HEADER_BYTES);
                  bad_in   = (NW'(req_item.data_offset) < NW'(HEADER_BYTES)) ||
                             (NW'(req_item.data_offset) > NW'(HEAP_BYTES));
                  state_in = ffha_pkg::ST_F_RD;
               end
            end
         end

         // Allocate: walk headers from the start
         ffha_pkg::ST_A_RD: begin
            if ((guard_ff == GW'(WORDS)) || !addr_ok(addr_ff)) begin
               stat_in  = ffha_pkg::STATUS_NO_FIT;
               state_in = ffha_pkg::ST_DONE;
            end else begin
               state_in = ffha_pkg::ST_A_CHK;
            end
         end

         ffha_pkg::ST_A_CHK: begin
            if (!e.marked || (e.size == '0)) begin
               stat_in  = ffha_pkg::STATUS_NO_FIT;
               state_in = ffha_pkg::ST_DONE;
            end else if (!e.used && (NW'(e.size) >= need_ff)) begin
               cur_in   = e;
               split_in = (NW'(e.size) - need_ff) > NW'(HEADER_BYTES);
               state_in = ((NW'(e.size) - need_ff) > NW'(HEADER_BYTES)) ?
                          ffha_pkg::ST_A_WNB : ffha_pkg::ST_A_WB;
            end else begin
               addr_in  = addr_ff + NW'(e.size);
               guard_in = guard_ff + GW'(1);
               state_in = ffha_pkg::ST_A_RD;
            end
         end

         // Write the split-off remainder header
         ffha_pkg::ST_A_WNB: begin
            we_c               = 1'b1;
            wr_idx_c           = word_idx(addr_ff + need_ff);
            wr_data_c.marked   = 1'b1;
            wr_data_c.used     = 1'b0;
            wr_data_c.has_prev = 1'b1;
            wr_data_c.size     = SZW'(rem);
            wr_data_c.prev     = BW'(addr_ff);
            aux_in             = nx;
            state_in           = ffha_pkg::ST_A_RDN;
         end

         ffha_pkg::ST_A_RDN: begin
            rd_idx_c = word_idx(aux_ff);
            state_in = addr_ok(aux_ff) ? ffha_pkg::ST_A_WN : ffha_pkg::ST_A_WB;
         end

         // Relink the block after the split
         ffha_pkg::ST_A_WN: begin
            wr_idx_c           = word_idx(aux_ff);
            wr_data_c          = e;
            wr_data_c.has_prev = 1'b1;
            wr_data_c.prev     = BW'(addr_ff + need_ff);
            we_c               = e.marked;
            state_in           = ffha_pkg::ST_A_WB;
         end

         ffha_pkg::ST_A_WB: begin
            we_c           = 1'b1;
            wr_data_c.used = 1'b1;
            if (split_ff) begin
               wr_data_c.size = SZW'(need_ff);
            end
            off_in   = ffha_pkg::OFF_W'(addr_ff + NW'(HEADER_BYTES));
            stat_in  = ffha_pkg::STATUS_DONE;
            state_in = ffha_pkg::ST_DONE;
         end

         // Free: check the header
         ffha_pkg::ST_F_RD: begin
            if (bad_ff || !addr_ok(addr_ff)) begin
               stat_in  = ffha_pkg::STATUS_IGNORED;
               state_in = ffha_pkg::ST_DONE;
            end else begin
               state_in = ffha_pkg::ST_F_CHK;
            end
         end

         ffha_pkg::ST_F_CHK: begin
            if (!e.marked) begin
               stat_in  = ffha_pkg::STATUS_IGNORED;
               state_in = ffha_pkg::ST_DONE;
            end else begin
               cur_in      = e;
               cur_in.used = 1'b0;
               aux_in      = NW'(e.prev);
               if (e.has_prev && addr_ok(NW'(e.prev))) begin
                  state_in = ffha_pkg::ST_F_RDP;
               end else begin
                  state_in = ffha_pkg::ST_F_RDN;
               end
            end
         end

         ffha_pkg::ST_F_RDP: begin
            rd_idx_c = word_idx(aux_ff);
            state_in = ffha_pkg::ST_F_CHKP;
         end

         // Merge into a free previous block
         ffha_pkg::ST_F_CHKP: begin
            if (e.marked && !e.used) begin
               we_c               = 1'b1;
               wr_data_c.marked   = 1'b0;
               wr_data_c.has_prev = 1'b0;
               wr_data_c.size     = '0;
               cur_in             = e;
               cur_in.size        = e.size + cur_ff.size;
               addr_in            = aux_ff;
               merged_in          = 1'b1;
            end
            state_in = ffha_pkg::ST_F_RDN;
         end

         ffha_pkg::ST_F_RDN: begin
            aux_in   = nx;
            rd_idx_c = word_idx(nx);
            state_in = addr_ok(nx) ? ffha_pkg::ST_F_CHKN : ffha_pkg::ST_F_WB;
         end

         // Merge with a free next block, or relink it
         ffha_pkg::ST_F_CHKN: begin
            wr_idx_c  = word_idx(aux_ff);
            wr_data_c = e;
            state_in  = ffha_pkg::ST_F_WB;
            if (e.marked) begin
               if (!e.used && (aux_ff != addr_ff)) begin
                  we_c               = 1'b1;
                  wr_data_c.marked   = 1'b0;
                  wr_data_c.has_prev = 1'b0;
                  wr_data_c.size     = '0;
                  sum                = NW'(cur_ff.size) + NW'(e.size);
                  cur_in.size        = SZW'(sum);
                  aux_in             = addr_ff + sum;
                  state_in           = ffha_pkg::ST_F_RDX;
               end else if (merged_ff) begin
                  we_c               = 1'b1;
                  wr_data_c.has_prev = 1'b1;
                  wr_data_c.prev     = BW'(addr_ff);
               end
            end
         end

         ffha_pkg::ST_F_RDX: begin
            rd_idx_c = word_idx(aux_ff);
            state_in = addr_ok(aux_ff) ? ffha_pkg::ST_F_CHKX : ffha_pkg::ST_F_WB;
         end

         ffha_pkg::ST_F_CHKX: begin
            wr_idx_c           = word_idx(aux_ff);
            wr_data_c          = e;
            wr_data_c.has_prev = 1'b1;
            wr_data_c.prev     = BW'(addr_ff);
            we_c               = e.marked;
            state_in           = ffha_pkg::ST_F_WB;
         end

         ffha_pkg::ST_F_WB: begin
            we_c           = 1'b1;
            wr_data_c.used = 1'b0;
            stat_in        = ffha_pkg::STATUS_DONE;
            state_in       = ffha_pkg::ST_DONE;
         end

         // Hand the result to the output register
         ffha_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.status        = stat_ff;
               rsp_item_in.result_offset = off_ff;
               state_in                  = ffha_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

   // No header is written while waiting for an item
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffha_pkg::ST_IDLE) |-> !we_c)
      else $error("header write while idle");

   // An accepted item always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ffha_pkg::ST_IDLE))
      else $error("accepted item not started");

   // Failed requests carry a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ffha_pkg::STATUS_DONE)) |->
      (rsp_item.result_offset == '0))
      else $error("non-zero offset on failed request");

   // A new result is only loaded when the output register is empty or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_item))
      else $error("waiting result overwritten");

endmodule
